### src/m4vt_pkg.sv
// Shared types, widths and register reset values for the 4x4 matrix-vector transform.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package m4vt_pkg;

    localparam int unsigned Q_W           = 32;
    localparam int unsigned LANES         = 4;
    localparam int unsigned PROD_W        = 2 * Q_W;
    localparam int unsigned PAIR_W        = PROD_W + 1;
    localparam int unsigned SUM_W         = PROD_W + 2;
    localparam int unsigned NUM_REGS      = 8;
    localparam int unsigned REG_W         = 64;
    localparam int unsigned REG_IDX_W     = $clog2(NUM_REGS);
    localparam int unsigned BYTE_SH       = $clog2(REG_W / 8);
    localparam int unsigned ADDR_W        = REG_IDX_W + BYTE_SH;
    localparam int unsigned FRAC_BITS_DEF = 16;

    // Identity matrix: 1.0 on the diagonal.
    localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000
    };

    localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    typedef logic signed [Q_W-1:0] q_t;
    typedef logic [LANES-1:0][Q_W-1:0] quad_t;

    typedef struct packed {
        q_t in_x;
        q_t in_y;
        q_t in_z;
        q_t in_w;
    } vec_t;

    typedef struct packed {
        q_t   out_x;
        q_t   out_y;
        q_t   out_z;
        q_t   out_w;
        logic saturated;
    } res_t;

    // Load enables of the lane pipeline stages.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

endpackage

### src/m4vt_lane.sv
// One row lane: four registered multiplies, a pair-add stage, final add with shift and clip.
// Depends on m4vt_pkg.
`timescale 1ns / 1ps

module m4vt_lane #(
    parameter int unsigned FRAC_BITS = m4vt_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  m4vt_pkg::stage_en_t en,
    input  m4vt_pkg::quad_t     row,
    input  m4vt_pkg::quad_t     vec,
    output m4vt_pkg::q_t        result,
    output logic                clip
);
    import m4vt_pkg::*;

    logic signed [PROD_W-1:0] prod_reg [LANES];
    logic signed [PAIR_W-1:0] pair_reg [2];
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  shifted;
    logic                     fits;
    q_t                       result_reg;
    q_t                       result_next;
    logic                     clip_reg;

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            for (int c = 0; c < LANES; c++)
            begin
                prod_reg[c] <= $signed(row[c]) * $signed(vec[c]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            pair_reg[0] <= PAIR_W'(prod_reg[0]) + PAIR_W'(prod_reg[1]);
            pair_reg[1] <= PAIR_W'(prod_reg[2]) + PAIR_W'(prod_reg[3]);
        end
    end

    // Exact row sum, then floor shift; fits when the bits above 31 are all sign copies.
    always_comb
    begin
        sum     = SUM_W'(pair_reg[0]) + SUM_W'(pair_reg[1]);
        shifted = sum >>> FRAC_BITS;
        fits    = (&shifted[SUM_W-1:Q_W-1]) | ~(|shifted[SUM_W-1:Q_W-1]);
        if (fits)
        begin
            result_next = shifted[Q_W-1:0];
        end
        else if (shifted[SUM_W-1])
        begin
            result_next = Q_MIN;
        end
        else
        begin
            result_next = Q_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            result_reg <= result_next;
            clip_reg   <= ~fits;
        end
    end

    assign result = result_reg;
    assign clip   = clip_reg;

endmodule

### src/m4vt_merge.sv
// Merge stage: packs the four lane results into the output request and ORs the clip flags.
// Depends on m4vt_pkg.
`timescale 1ns / 1ps

module m4vt_merge (
    input  logic                        clk,
    input  logic                        en,
    input  m4vt_pkg::quad_t             lane_result,
    input  logic [m4vt_pkg::LANES-1:0]  lane_clip,
    output m4vt_pkg::res_t              res
);
    import m4vt_pkg::*;

    res_t res_reg;
    res_t res_next;

    always_comb
    begin
        res_next.out_x     = lane_result[0];
        res_next.out_y     = lane_result[1];
        res_next.out_z     = lane_result[2];
        res_next.out_w     = lane_result[3];
        res_next.saturated = |lane_clip;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

### src/matrix4_vector_transform.sv
// matrix4_vector_transform: multiplies each request vector (signed Q16.16 x, y, z, w) by a
// 4x4 matrix held in eight 64-bit APB registers (rowR_colsAB at byte 8*index, column A in
// the low word, column B in the high word; reset gives the identity). The block accepts one
// vector per clock while the output side is not stalled, and returns one result per vector
// through the four-stage pipeline: sixteen 32x32 multipliers (one lane of four per matrix
// row) register their products, a pair-add stage follows, then the exact 66-bit row sum,
// arithmetic shift by FRAC_BITS and clip to 32 bits, then the merge stage that builds the
// result and its saturated flag. Each stage holds its request while the next is full, so
// a waiting result never blocks new requests until all four stages are occupied. Depends on
// m4vt_pkg, m4vt_lane and m4vt_merge.
`timescale 1ns / 1ps

module matrix4_vector_transform #(
    parameter int unsigned FRAC_BITS = m4vt_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // vector request channel
    input  logic                          vec_valid,
    output logic                          vec_ready,
    input  m4vt_pkg::vec_t                vec,
    // result channel
    output logic                          res_valid,
    input  logic                          res_ready,
    output m4vt_pkg::res_t                res,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [m4vt_pkg::ADDR_W-1:0]   paddr,
    input  logic [m4vt_pkg::REG_W-1:0]    pwdata,
    output logic [m4vt_pkg::REG_W-1:0]    prdata,
    output logic                          pready
);
    import m4vt_pkg::*;

    // ---------------------------------------------------------------------
    // Matrix registers
    // ---------------------------------------------------------------------
    logic [REG_W-1:0]     cfg_reg [NUM_REGS];
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;

    assign reg_idx   = paddr[ADDR_W-1:BYTE_SH];
    assign cfg_write = psel & penable & pwrite;
    assign pready    = 1'b1;
    assign prdata    = cfg_reg[reg_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cfg_reg[i] <= REG_RESET[i];
            end
        end
        else if (cfg_write)
        begin
            cfg_reg[reg_idx] <= pwdata;
        end
    end

    // ---------------------------------------------------------------------
    // Pipeline control: a stage loads when it is empty or its request moves on.
    // ---------------------------------------------------------------------
    logic      v1_reg, v2_reg, v3_reg, vo_reg;
    logic      v1_next, v2_next, v3_next, vo_next;
    logic      out_en;
    stage_en_t lane_en;

    always_comb
    begin
        out_en     = ~vo_reg | res_ready;
        lane_en.s3 = ~v3_reg | out_en;
        lane_en.s2 = ~v2_reg | lane_en.s3;
        lane_en.s1 = ~v1_reg | lane_en.s2;

        v1_next = lane_en.s1 ? vec_valid : v1_reg;
        v2_next = lane_en.s2 ? v1_reg    : v2_reg;
        v3_next = lane_en.s3 ? v2_reg    : v3_reg;
        vo_next = out_en     ? v3_reg    : vo_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            vo_reg <= vo_next;
        end
    end

    assign vec_ready = lane_en.s1;
    assign res_valid = vo_reg;

    // ---------------------------------------------------------------------
    // Row lanes: lane r computes row r dotted with the vector.
    // ---------------------------------------------------------------------
    quad_t             vec_q;
    quad_t             lane_result;
    logic [LANES-1:0]  lane_clip;

    assign vec_q[0] = vec.in_x;
    assign vec_q[1] = vec.in_y;
    assign vec_q[2] = vec.in_z;
    assign vec_q[3] = vec.in_w;

    for (genvar r = 0; r < LANES; r++)
    begin : g_lane
        quad_t row_q;

        // Two registers per row: low register holds columns 0/1, high register 2/3.
        assign row_q[0] = cfg_reg[2*r][Q_W-1:0];
        assign row_q[1] = cfg_reg[2*r][REG_W-1:Q_W];
        assign row_q[2] = cfg_reg[2*r+1][Q_W-1:0];
        assign row_q[3] = cfg_reg[2*r+1][REG_W-1:Q_W];

        m4vt_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk    (clk),
            .en     (lane_en),
            .row    (row_q),
            .vec    (vec_q),
            .result (lane_result[r]),
            .clip   (lane_clip[r])
        );
    end

    // ---------------------------------------------------------------------
    // Merge into the output register
    // ---------------------------------------------------------------------
    m4vt_merge u_merge (
        .clk         (clk),
        .en          (out_en),
        .lane_result (lane_result),
        .lane_clip   (lane_clip),
        .res         (res)
    );

`ifndef SYNTHESIS
    // accepted request always lands in the first stage
    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (vec_valid && vec_ready) |=> v1_reg)
        else $error("accepted request did not enter stage 1");

    // input stalls only when every stage holds a request
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !vec_ready |-> (v1_reg && v2_reg && v3_reg && vo_reg && !res_ready))
        else $error("input stalled with a free pipeline stage");

    // a finished row sum moving on shows up as a valid result
    a_s3_to_output: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && out_en) |=> res_valid)
        else $error("stage 3 request lost on its way to the output");

    // a result that is not taken is not dropped
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res)))
        else $error("stalled result dropped or changed");
`endif

endmodule

### tb/matrix4_vector_transform_tb.sv
// Self-checking testbench for matrix4_vector_transform: random and directed vector requests
// checked against an in-bench Q16.16 matrix-vector predictor. Depends on m4vt_pkg and the DUT.
`timescale 1ns / 1ps

module matrix4_vector_transform_tb;

    import m4vt_pkg::*;

    localparam int unsigned FRAC        = FRAC_BITS_DEF;
    localparam int unsigned DRAIN_WAIT  = 12;       // pipeline is four deep, pad generously
    localparam int unsigned HOLD_AT     = 400;      // result count that triggers the long stall
    localparam int unsigned HOLD_LEN    = 300;      // cycles of that stall
    localparam int unsigned RAND_PHASES = 10;
    localparam int unsigned PHASE_ITEMS = 160;
    localparam longint      LIMIT_NS    = 64'd10_000_000;

    // Register map: rowR_colsAB at byte 8 * index.
    localparam int unsigned REG_ROW0_COLS01 = 0;
    localparam int unsigned REG_BYTES       = REG_W / 8;

    localparam q_t Q_ONE  = 32'sh0001_0000;
    localparam q_t Q_HALF = 32'sh0000_8000;

    // Exact row sum after the shift must fit in this window, else it clips.
    localparam logic signed [SUM_W-1:0] SUM_HI = 66'sd2147483647;
    localparam logic signed [SUM_W-1:0] SUM_LO = -66'sd2147483648;

    typedef enum int unsigned {
        MAT_IDENTITY,
        MAT_HALF,
        MAT_ALL_MIN,
        MAT_ALL_MAX,
        MAT_FULL,
        MAT_MODERATE,
        MAT_MIXED
    } mat_kind_e;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              vec_valid = 1'b0;
    logic              vec_ready;
    vec_t              vec = '0;
    logic              res_valid;
    logic              res_ready = 1'b0;
    res_t              res;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [REG_W-1:0]  pwdata = '0;
    logic [REG_W-1:0]  prdata;
    logic              pready;

    // Shadow of the matrix registers, only touched while the block is idle.
    logic [REG_W-1:0] mat_regs [NUM_REGS];

    vec_t pending_vecs [$];     // requests not yet offered
    res_t expected_res [$];     // predicted results, oldest first

    int unsigned n_queued   = 0;
    int unsigned n_accepted = 0;
    int unsigned n_results  = 0;
    int unsigned errors     = 0;

    // Sender side pacing
    int unsigned src_gap       = 0;
    int unsigned src_calm_left = 0;
    bit          src_calm      = 1'b0;

    // Receiver side pacing
    int unsigned sink_stall     = 0;
    int unsigned sink_calm_left = 0;
    bit          sink_calm      = 1'b0;
    int unsigned hold_left      = 0;
    bit          hold_done      = 1'b0;

    matrix4_vector_transform dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .vec_valid (vec_valid),
        .vec_ready (vec_ready),
        .vec       (vec),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor: each row is the exact 66-bit sum of four 32x32 signed
    // products, shifted arithmetically (floor) and clipped to 32 bits.
    // ------------------------------------------------------------------
    function automatic res_t transform(vec_t v);
        logic signed [SUM_W-1:0] acc;
        logic signed [SUM_W-1:0] lhs;
        logic signed [SUM_W-1:0] rhs;
        logic [REG_W-1:0]        word;
        q_t                      lane [LANES];
        q_t                      comp [LANES];
        res_t                    r;
        r = '0;
        lane[0] = v.in_x;
        lane[1] = v.in_y;
        lane[2] = v.in_z;
        lane[3] = v.in_w;
        for (int row = 0; row < LANES; row++)
        begin
            acc = '0;
            for (int col = 0; col < LANES; col++)
            begin
                // column A of rowR_colsAB sits in the low word, column B in the high word
                word = mat_regs[REG_ROW0_COLS01 + 2 * row + col / 2];
                lhs  = q_t'(col[0] ? word[2*Q_W-1:Q_W] : word[Q_W-1:0]);
                rhs  = lane[col];
                acc  = acc + lhs * rhs;
            end
            acc = acc >>> FRAC;
            if (acc > SUM_HI)
            begin
                comp[row]   = Q_MAX;
                r.saturated = 1'b1;
            end
            else if (acc < SUM_LO)
            begin
                comp[row]   = Q_MIN;
                r.saturated = 1'b1;
            end
            else
                comp[row] = acc[Q_W-1:0];
        end
        r.out_x = comp[0];
        r.out_y = comp[1];
        r.out_z = comp[2];
        r.out_w = comp[3];
        return r;
    endfunction

    // Mostly back-to-back, some short gaps, the odd long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Vector component: full range, small values, rails and tiny values around zero.
    function automatic q_t rand_comp();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 4)
            return q_t'($urandom);
        else if (roll < 7)
            return q_t'($urandom_range(0, 32'h001F_FFFF)) - q_t'(32'h0010_0000);
        else if (roll == 7)
            return Q_MAX;
        else if (roll == 8)
            return Q_MIN;
        else
            return q_t'($urandom_range(0, 4)) - q_t'(2);
    endfunction

    function automatic q_t mat_entry(mat_kind_e kind, int row, int col);
        int unsigned roll;
        case (kind)
            MAT_IDENTITY: return (row == col) ? Q_ONE : '0;
            MAT_HALF:     return Q_HALF;
            MAT_ALL_MIN:  return Q_MIN;
            MAT_ALL_MAX:  return Q_MAX;
            MAT_FULL:     return q_t'($urandom);
            MAT_MODERATE: return q_t'($urandom_range(0, 32'h0003_FFFF)) - q_t'(32'h0002_0000);
            default:
            begin
                roll = $urandom_range(0, 5);
                case (roll)
                    0:       return Q_MAX;
                    1:       return Q_MIN;
                    2:       return '0;
                    3:       return Q_ONE;
                    4:       return -Q_ONE;
                    default: return q_t'($urandom);
                endcase
            end
        endcase
    endfunction

    function automatic vec_t make_vec(q_t x, q_t y, q_t z, q_t w);
        vec_t v;
        v.in_x = x;
        v.in_y = y;
        v.in_z = z;
        v.in_w = w;
        return v;
    endfunction

    task automatic queue_vec(vec_t v);
        pending_vecs.push_back(v);
        n_queued++;
    endtask

    // APB write: setup then access; the register takes the data at the access edge.
    task automatic apb_write(int unsigned idx, logic [REG_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * REG_BYTES);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        mat_regs[idx] = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_matrix(mat_kind_e kind);
        q_t lo_word;
        q_t hi_word;
        for (int row = 0; row < LANES; row++)
            for (int half = 0; half < 2; half++)
            begin
                lo_word = mat_entry(kind, row, 2 * half);
                hi_word = mat_entry(kind, row, 2 * half + 1);
                apb_write(REG_ROW0_COLS01 + 2 * row + half, {hi_word, lo_word});
            end
    endtask

    // Wait until every request is in and every result is out, then let the pipe settle.
    task automatic wait_idle();
        while (n_accepted != n_queued || expected_res.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic cmp_field(string name, logic [Q_W-1:0] want, logic [Q_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: mismatch on %s: expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------
    // Request driver: offers queued vectors, holds each one until taken,
    // and books the prediction at the accepting edge.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : vec_driver
        logic next_valid;
        if (!rst_n)
        begin
            vec_valid <= 1'b0;
            vec       <= '0;
        end
        else
        begin
            next_valid = vec_valid;
            if (vec_valid && vec_ready)
            begin
                expected_res.push_back(transform(vec));
                n_accepted++;
                next_valid = 1'b0;
            end
            // alternate between stretches with no gaps and stretches with random gaps
            if (src_calm_left == 0)
            begin
                src_calm      = ($urandom_range(0, 3) == 0);
                src_calm_left = $urandom_range(16, 160);
            end
            else
                src_calm_left--;
            if (!next_valid)
            begin
                if (src_gap > 0)
                    src_gap--;
                else if (pending_vecs.size() > 0)
                begin
                    vec        <= pending_vecs.pop_front();
                    next_valid = 1'b1;
                    src_gap    = src_calm ? 0 : pick_gap();
                end
            end
            vec_valid <= next_valid;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: checks each result against the oldest prediction
    // and paces res_ready, including one long hold that backs up the
    // pipeline while the driver keeps offering.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : res_monitor
        logic next_ready;
        res_t want;
        if (!rst_n)
            res_ready <= 1'b0;
        else
        begin
            if (res_valid && res_ready)
            begin
                if (expected_res.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, got %h", $time, res);
                    errors++;
                end
                else
                begin
                    want = expected_res.pop_front();
                    cmp_field("out_x", want.out_x, res.out_x);
                    cmp_field("out_y", want.out_y, res.out_y);
                    cmp_field("out_z", want.out_z, res.out_z);
                    cmp_field("out_w", want.out_w, res.out_w);
                    cmp_field("saturated", Q_W'(want.saturated), Q_W'(res.saturated));
                end
                n_results++;
            end
            if (sink_calm_left == 0)
            begin
                sink_calm      = ($urandom_range(0, 3) == 0);
                sink_calm_left = $urandom_range(16, 160);
            end
            else
                sink_calm_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                next_ready = 1'b0;
            end
            else if (!hold_done && n_results >= HOLD_AT)
            begin
                hold_done  = 1'b1;
                hold_left  = HOLD_LEN - 1;
                next_ready = 1'b0;
            end
            else if (sink_stall > 0)
            begin
                sink_stall--;
                next_ready = 1'b0;
            end
            else if (!sink_calm && $urandom_range(0, 2) == 0)
            begin
                sink_stall = pick_gap();
                next_ready = 1'b0;
            end
            else
                next_ready = 1'b1;
            res_ready <= next_ready;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence. Each phase drains fully before the matrix is
    // rewritten, so the sender also pauses until all results are back.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        mat_kind_e kind;
        for (int i = 0; i < NUM_REGS; i++)
            mat_regs[i] = REG_RESET[i];
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset matrix is the identity: values pass through, rails included.
        queue_vec(make_vec('0, '0, '0, '0));
        queue_vec(make_vec(Q_MAX, Q_MIN, q_t'(1), q_t'(-1)));
        queue_vec(make_vec(Q_ONE, -Q_ONE, 32'sh0001_8000, -32'sh0001_8000));
        queue_vec(make_vec(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        queue_vec(make_vec(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        wait_idle();

        // All entries 0.5: odd LSBs show the floor rounding, rails add up past the range.
        program_matrix(MAT_HALF);
        queue_vec(make_vec(q_t'(-1), '0, '0, '0));
        queue_vec(make_vec(q_t'(1), '0, '0, '0));
        queue_vec(make_vec(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        queue_vec(make_vec(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        queue_vec(make_vec(Q_MAX, Q_MIN, Q_MAX, Q_MIN));
        wait_idle();

        // Most negative entries: the row sum reaches 2^64, needing the full sum width.
        program_matrix(MAT_ALL_MIN);
        queue_vec(make_vec(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        queue_vec(make_vec(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        queue_vec(make_vec('0, '0, '0, '0));
        queue_vec(make_vec(q_t'(1), '0, '0, '0));
        wait_idle();

        // Most positive entries: clipping on both sides and a near-cancelling mix.
        program_matrix(MAT_ALL_MAX);
        queue_vec(make_vec(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        queue_vec(make_vec(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        queue_vec(make_vec(Q_MAX, Q_MIN, '0, '0));
        queue_vec(make_vec(q_t'(-1), q_t'(1), q_t'(-1), q_t'(1)));
        wait_idle();

        // Random phases, each under a fresh matrix.
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            case (p % 5)
                0:       kind = MAT_MODERATE;
                1:       kind = MAT_FULL;
                2:       kind = MAT_MIXED;
                3:       kind = MAT_MODERATE;
                default: kind = MAT_IDENTITY;
            endcase
            program_matrix(kind);
            for (int n = 0; n < PHASE_ITEMS; n++)
                queue_vec(make_vec(rand_comp(), rand_comp(), rand_comp(), rand_comp()));
            wait_idle();
        end

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog for a hung handshake or a lost result.
    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

endmodule

### filelist.f
src/m4vt_pkg.sv
src/m4vt_lane.sv
src/m4vt_merge.sv
src/matrix4_vector_transform.sv
tb/matrix4_vector_transform_tb.sv
